FILE: rtl/grid_bfs_next_step_core_macros.svh
// Assertion macros for the grid search core.
// Both sample on clk_i and stay quiet while rst_ni is low.
`ifndef GRID_BFS_NEXT_STEP_CORE_MACROS_SVH
`define GRID_BFS_NEXT_STEP_CORE_MACROS_SVH

// Invariant that holds at every edge.
`define GBFS_ASSERT(name, prop, msg) \
  name: assert property (@(posedge clk_i) disable iff (!rst_ni) (prop)) \
    else $error(msg);

// Antecedent now implies consequent at the same edge.
`define GBFS_ASSERT_IMPL(name, ante, cons, msg) \
  name: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |-> (cons)) \
    else $error(msg);

`endif

FILE: rtl/gbfs_pkg.sv
`default_nettype none
package gbfs_pkg;

  localparam int unsigned COORD_W    = 5;
  localparam int unsigned GRID_COLS  = 1 << COORD_W;
  localparam int unsigned GRID_ROWS  = 1 << COORD_W;
  localparam int unsigned CELL_W     = 2 * COORD_W;
  localparam int unsigned CELL_COUNT = GRID_COLS * GRID_ROWS;
  localparam int unsigned CNT_W      = CELL_W + 1;

  typedef enum logic {
    OP_WRITE = 1'b0,
    OP_QUERY = 1'b1
  } op_e;

  // Neighbour order and step direction share one code.
  typedef enum logic [1:0] {
    DIR_LEFT  = 2'd0,
    DIR_RIGHT = 2'd1,
    DIR_UP    = 2'd2,
    DIR_DOWN  = 2'd3
  } dir_e;

  // How a cell was reached from its parent.
  typedef enum logic [2:0] {
    MARK_NONE   = 3'd0,
    MARK_LEFT   = 3'd1,
    MARK_RIGHT  = 3'd2,
    MARK_UP     = 3'd3,
    MARK_DOWN   = 3'd4,
    MARK_ORIGIN = 3'd5
  } mark_e;

  typedef struct packed {
    logic              wall_we;
    logic              wall_wdata;
    logic              mark_we;
    mark_e             mark_wdata;
    logic [CELL_W-1:0] wr_addr;
    logic [CELL_W-1:0] rd_addr;
  } cell_req_t;

endpackage
`default_nettype wire

FILE: rtl/grid_bfs_next_step_core.sv
// Wall write item: taken while idle, gives no result.
// Query item: a mark clear over all 1024 cells, seeding, then a pop and a goal test per
// cell dequeued plus a check of each neighbour of every cell that is not the start, then
// the hand-over; one item in flight, set by the single cell port.
// Reset: asynchronous, active low; a pass over all 1024 cells then clears walls and marks,
// with in_stall_o high throughout.
`default_nettype none
`include "grid_bfs_next_step_core_macros.svh"
module grid_bfs_next_step_core (
  input  logic                         clk_i,
  input  logic                         rst_ni,
  input  logic                         in_valid_i,
  output logic                         in_stall_o,
  input  logic                         operation_i,
  input  logic [gbfs_pkg::COORD_W-1:0] cell_x_i,
  input  logic [gbfs_pkg::COORD_W-1:0] cell_y_i,
  input  logic                         wall_bit_i,
  input  logic [gbfs_pkg::COORD_W-1:0] target_x_i,
  input  logic [gbfs_pkg::COORD_W-1:0] target_y_i,
  input  logic [gbfs_pkg::COORD_W-1:0] start_x_i,
  input  logic [gbfs_pkg::COORD_W-1:0] start_y_i,
  output logic                         out_valid_o,
  input  logic                         out_stall_i,
  output logic [1:0]                   direction_o,
  output logic                         path_found_o
);
  import gbfs_pkg::*;

  // Sequencer states, one-hot.
  typedef enum logic [7:0] {
    ST_RST_CLR = 8'b0000_0001, // clear walls and marks after reset
    ST_IDLE    = 8'b0000_0010, // take write or query items
    ST_CLEAR   = 8'b0000_0100, // wipe visit marks for a new query
    ST_INIT    = 8'b0000_1000, // seed the queue with the target
    ST_POP     = 8'b0001_0000, // read the queue head
    ST_CUR     = 8'b0010_0000, // queue data back: goal test, first neighbour read
    ST_NB      = 8'b0100_0000, // check one neighbour, read the next
    ST_DONE    = 8'b1000_0000  // hand the result to the output register
  } state_e;

  // Step from a cell toward one neighbour, wrapping at the grid edge.
  function automatic logic [CELL_W-1:0] nb_cell(input logic [CELL_W-1:0] c, input dir_e k);
    logic [COORD_W-1:0] x;
    logic [COORD_W-1:0] y;
    x = c[COORD_W-1:0];
    y = c[CELL_W-1:COORD_W];
    unique case (k)
      DIR_LEFT:  x = x - 1'b1;
      DIR_RIGHT: x = x + 1'b1;
      DIR_UP:    y = y - 1'b1;
      DIR_DOWN:  y = y + 1'b1;
      default:   x = x;
    endcase
    return {y, x};
  endfunction

  // Neighbour lies inside the grid.
  function automatic logic nb_ok(input logic [CELL_W-1:0] c, input dir_e k);
    logic [COORD_W-1:0] x;
    logic [COORD_W-1:0] y;
    logic               ok;
    x = c[COORD_W-1:0];
    y = c[CELL_W-1:COORD_W];
    unique case (k)
      DIR_LEFT:  ok = (x != '0);
      DIR_RIGHT: ok = (x != COORD_W'(GRID_COLS - 1));
      DIR_UP:    ok = (y != '0);
      DIR_DOWN:  ok = (y != COORD_W'(GRID_ROWS - 1));
      default:   ok = 1'b0;
    endcase
    return ok;
  endfunction

  function automatic mark_e nb_mark(input dir_e k);
    mark_e m;
    unique case (k)
      DIR_LEFT:  m = MARK_LEFT;
      DIR_RIGHT: m = MARK_RIGHT;
      DIR_UP:    m = MARK_UP;
      DIR_DOWN:  m = MARK_DOWN;
      default:   m = MARK_NONE;
    endcase
    return m;
  endfunction

  state_e            state_q, state_d;
  logic [CELL_W-1:0] clr_q, clr_d;
  logic [CNT_W-1:0]  head_q, head_d;
  logic [CNT_W-1:0]  tail_q, tail_d;
  logic [CELL_W-1:0] cur_q, cur_d;
  logic [CELL_W-1:0] goal_q, goal_d;
  logic [CELL_W-1:0] origin_q, origin_d;
  dir_e              nb_q, nb_d;
  mark_e             goal_mark_q, goal_mark_d;
  logic              res_found_q, res_found_d;
  dir_e              res_dir_q, res_dir_d;
  logic              out_valid_q, out_valid_d;
  logic              out_found_q, out_found_d;
  dir_e              out_dir_q, out_dir_d;

  cell_req_t         cell_req;
  logic              wall_rd;
  mark_e             mark_rd;
  logic              q_we;
  logic [CELL_W-1:0] q_waddr;
  logic [CELL_W-1:0] q_wdata;
  logic [CELL_W-1:0] q_raddr;
  logic [CELL_W-1:0] q_rdata;

  logic              in_accept;
  logic              out_free;
  logic [CELL_W-1:0] nb_addr;
  logic              nb_take;
  dir_e              nb_next;

  gbfs_cell_mem u_cell_mem (
    .clk_i     (clk_i),
    .req_i     (cell_req),
    .wall_rd_o (wall_rd),
    .mark_rd_o (mark_rd)
  );

  gbfs_queue_mem u_queue_mem (
    .clk_i   (clk_i),
    .we_i    (q_we),
    .waddr_i (q_waddr),
    .wdata_i (q_wdata),
    .raddr_i (q_raddr),
    .rdata_o (q_rdata)
  );

  assign in_stall_o = (state_q != ST_IDLE);
  assign in_accept  = in_valid_i && !in_stall_o;
  // Output register can take a new item when empty or being drained.
  assign out_free   = !out_valid_q || !out_stall_i;

  // Neighbour under check in ST_NB; its cell data arrives this cycle.
  assign nb_addr = nb_cell(cur_q, nb_q);
  assign nb_take = nb_ok(cur_q, nb_q) && !wall_rd && (mark_rd == MARK_NONE);
  assign nb_next = dir_e'(nb_q + 1'b1);

  always_comb begin
    state_d     = state_q;
    clr_d       = clr_q;
    head_d      = head_q;
    tail_d      = tail_q;
    cur_d       = cur_q;
    goal_d      = goal_q;
    origin_d    = origin_q;
    nb_d        = nb_q;
    goal_mark_d = goal_mark_q;
    res_found_d = res_found_q;
    res_dir_d   = res_dir_q;

    cell_req    = '{wall_we: 1'b0, wall_wdata: 1'b0, mark_we: 1'b0, mark_wdata: MARK_NONE,
                    wr_addr: '0, rd_addr: '0};
    q_we        = 1'b0;
    q_waddr     = tail_q[CELL_W-1:0];
    q_wdata     = '0;
    q_raddr     = head_q[CELL_W-1:0];

    unique case (state_q)
      ST_RST_CLR: begin
        // Sweep every cell back to open and unvisited.
        cell_req.wall_we = 1'b1;
        cell_req.mark_we = 1'b1;
        cell_req.wr_addr = clr_q;
        clr_d            = clr_q + 1'b1;
        if (clr_q == '1) begin
          state_d = ST_IDLE;
        end
      end
      ST_IDLE: begin
        if (in_accept) begin
          if (op_e'(operation_i) == OP_WRITE) begin
            // Whole 5-bit range is on the grid, so every write lands.
            cell_req.wall_we    = 1'b1;
            cell_req.wall_wdata = wall_bit_i;
            cell_req.wr_addr    = {cell_y_i, cell_x_i};
          end else begin
            goal_d   = {start_y_i, start_x_i};
            origin_d = {target_y_i, target_x_i};
            clr_d    = '0;
            state_d  = ST_CLEAR;
          end
        end
      end
      ST_CLEAR: begin
        cell_req.mark_we = 1'b1;
        cell_req.wr_addr = clr_q;
        clr_d            = clr_q + 1'b1;
        if (clr_q == '1) begin
          state_d = ST_INIT;
        end
      end
      ST_INIT: begin
        // Target is the origin even when it sits on a wall.
        cell_req.mark_we    = 1'b1;
        cell_req.mark_wdata = MARK_ORIGIN;
        cell_req.wr_addr    = origin_q;
        q_we                = 1'b1;
        q_waddr             = '0;
        q_wdata             = origin_q;
        head_d              = '0;
        tail_d              = CNT_W'(1);
        goal_mark_d         = (origin_q == goal_q) ? MARK_ORIGIN : MARK_NONE;
        state_d             = ST_POP;
      end
      ST_POP: begin
        if (head_q != tail_q) begin
          q_raddr = head_q[CELL_W-1:0];
          head_d  = head_q + 1'b1;
          state_d = ST_CUR;
        end else begin
          // Queue ran dry: start never reached.
          res_found_d = 1'b0;
          res_dir_d   = DIR_LEFT;
          state_d     = ST_DONE;
        end
      end
      ST_CUR: begin
        if (q_rdata == goal_q) begin
          // Step back against the way the start was reached.
          unique case (goal_mark_q)
            MARK_LEFT: begin
              res_found_d = 1'b1;
              res_dir_d   = DIR_RIGHT;
            end
            MARK_RIGHT: begin
              res_found_d = 1'b1;
              res_dir_d   = DIR_LEFT;
            end
            MARK_UP: begin
              res_found_d = 1'b1;
              res_dir_d   = DIR_DOWN;
            end
            MARK_DOWN: begin
              res_found_d = 1'b1;
              res_dir_d   = DIR_UP;
            end
            default: begin
              // Start equals target.
              res_found_d = 1'b0;
              res_dir_d   = DIR_LEFT;
            end
          endcase
          state_d = ST_DONE;
        end else begin
          cur_d            = q_rdata;
          cell_req.rd_addr = nb_cell(q_rdata, DIR_LEFT);
          nb_d             = DIR_LEFT;
          state_d          = ST_NB;
        end
      end
      ST_NB: begin
        // Write this neighbour and read the next one: always distinct cells.
        if (nb_take) begin
          cell_req.mark_we    = 1'b1;
          cell_req.mark_wdata = nb_mark(nb_q);
          cell_req.wr_addr    = nb_addr;
          q_we                = 1'b1;
          q_waddr             = tail_q[CELL_W-1:0];
          q_wdata             = nb_addr;
          tail_d              = tail_q + 1'b1;
          if (nb_addr == goal_q) begin
            goal_mark_d = nb_mark(nb_q);
          end
        end
        if (nb_q == DIR_DOWN) begin
          state_d = ST_POP;
        end else begin
          cell_req.rd_addr = nb_cell(cur_q, nb_next);
          nb_d             = nb_next;
        end
      end
      ST_DONE: begin
        if (out_free) begin
          state_d = ST_IDLE;
        end
      end
      default: begin
        state_d = ST_IDLE;
      end
    endcase
  end

  // Output register: load on hand-over, drop once taken downstream.
  always_comb begin
    out_valid_d = out_valid_q;
    out_found_d = out_found_q;
    out_dir_d   = out_dir_q;
    if ((state_q == ST_DONE) && out_free) begin
      out_valid_d = 1'b1;
      out_found_d = res_found_q;
      out_dir_d   = res_dir_q;
    end else if (out_valid_q && !out_stall_i) begin
      out_valid_d = 1'b0;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= ST_RST_CLR;
      clr_q       <= '0;
      head_q      <= '0;
      tail_q      <= '0;
      out_valid_q <= 1'b0;
    end else begin
      state_q     <= state_d;
      clr_q       <= clr_d;
      head_q      <= head_d;
      tail_q      <= tail_d;
      out_valid_q <= out_valid_d;
    end
  end

  // Payload registers: no reset.
  always_ff @(posedge clk_i) begin
    cur_q       <= cur_d;
    goal_q      <= goal_d;
    origin_q    <= origin_d;
    nb_q        <= nb_d;
    goal_mark_q <= goal_mark_d;
    res_found_q <= res_found_d;
    res_dir_q   <= res_dir_d;
    out_found_q <= out_found_d;
    out_dir_q   <= out_dir_d;
  end

  assign out_valid_o  = out_valid_q;
  assign path_found_o = out_found_q;
  assign direction_o  = out_dir_q;

  // Each cell enters the queue at most once.
  `GBFS_ASSERT(a_tail_bound, tail_q <= CNT_W'(CELL_COUNT), "queue tail beyond cell count")
  // Head never overtakes tail while searching.
  `GBFS_ASSERT_IMPL(a_head_le_tail, (state_q == ST_POP) || (state_q == ST_CUR) || (state_q == ST_NB),
                    head_q <= tail_q, "queue head past tail")
  // A new result appears only after a finished search.
  `GBFS_ASSERT_IMPL(a_out_from_done, $rose(out_valid_q), $past(state_q) == ST_DONE,
                    "result raised outside hand-over")
  // No path reports the left code.
  `GBFS_ASSERT_IMPL(a_nopath_dir, out_valid_q && !out_found_q, out_dir_q == DIR_LEFT,
                    "direction not cleared without a path")

endmodule
`default_nettype wire

FILE: rtl/gbfs_cell_mem.sv
`default_nettype none
module gbfs_cell_mem (
  input  logic                  clk_i,
  input  gbfs_pkg::cell_req_t   req_i,
  output logic                  wall_rd_o,
  output gbfs_pkg::mark_e       mark_rd_o
);
  import gbfs_pkg::*;

  logic  wall_mem [CELL_COUNT];
  mark_e mark_mem [CELL_COUNT];
  logic  wall_rd_q;
  mark_e mark_rd_q;

  always_ff @(posedge clk_i) begin
    if (req_i.wall_we) begin
      wall_mem[req_i.wr_addr] <= req_i.wall_wdata;
    end
    if (req_i.mark_we) begin
      mark_mem[req_i.wr_addr] <= req_i.mark_wdata;
    end
    wall_rd_q <= wall_mem[req_i.rd_addr];
    mark_rd_q <= mark_mem[req_i.rd_addr];
  end

  assign wall_rd_o = wall_rd_q;
  assign mark_rd_o = mark_rd_q;

endmodule
`default_nettype wire

FILE: rtl/gbfs_queue_mem.sv
`default_nettype none
module gbfs_queue_mem (
  input  logic                        clk_i,
  input  logic                        we_i,
  input  logic [gbfs_pkg::CELL_W-1:0] waddr_i,
  input  logic [gbfs_pkg::CELL_W-1:0] wdata_i,
  input  logic [gbfs_pkg::CELL_W-1:0] raddr_i,
  output logic [gbfs_pkg::CELL_W-1:0] rdata_o
);
  import gbfs_pkg::*;

  logic [CELL_W-1:0] mem [CELL_COUNT];
  logic [CELL_W-1:0] rdata_q;

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem[waddr_i] <= wdata_i;
    end
    rdata_q <= mem[raddr_i];
  end

  assign rdata_o = rdata_q;

endmodule
`default_nettype wire
